// ===== rtl/core/nwrc_pkg.sv =====
// Shared types, widths and constants of the nearest wall ray cast core.
`timescale 1ns / 1ps
`default_nettype none

package nwrc_pkg;

  // Table size and direction precision
  localparam int MAX_WALLS  = 64;
  localparam int TRIG_BITS  = 16;

  localparam int WALL_IDX_W = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
  localparam int CNT_W      = $clog2(MAX_WALLS + 1);
  localparam int COORD_W    = 32;
  localparam int PT_W       = 2 * COORD_W;

  // Datapath widths
  localparam int DIFF_W   = COORD_W + 1;           // wall vector, offset from robot
  localparam int DIR_W    = TRIG_BITS + 2;         // signed cos / sin
  localparam int DEN_W    = DIR_W + DIFF_W + 1;    // cross products
  localparam int MAG_W    = DEN_W - 1;             // |den|, divisor
  localparam int QUO_W    = DIFF_W;                // quotient, at most |w|
  localparam int PROD_W   = MAG_W + QUO_W;         // num * |w|, dividend
  localparam int HIT_W    = DIFF_W + 1;
  localparam int EX_W     = HIT_W + 1;             // hit minus robot
  localparam int DOT_W    = EX_W + DIR_W + 1;
  localparam int SQ_W     = 64;                    // squared distance, mod 2^64
  localparam int DIST_W   = SQ_W + 1;
  localparam int MB_W     = (DIR_W > 18) ? DIR_W : 18;
  localparam int CHUNK_W  = MB_W - 1;
  localparam int MA_W     = DEN_W + 1;
  localparam int MP_W     = MA_W + MB_W;
  localparam int ITER_W   = $clog2(TRIG_BITS);
  localparam int ANG_W    = 34;
  localparam int DCNT_W   = $clog2(QUO_W + 1);

  // CORDIC start value: inverse gain rounded to TRIG_BITS fraction bits
  localparam logic [63:0] INV_GAIN_Q30 = 64'd652032874;
  localparam logic signed [DIR_W-1:0] CORDIC_X0 =
    DIR_W'((INV_GAIN_Q30 + (64'd1 << (29 - TRIG_BITS))) >> (30 - TRIG_BITS));

  // Command and status codes
  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_RAY = 1'b1;

  localparam logic [1:0] ST_STORED = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_HIT    = 2'd2;
  localparam logic [1:0] ST_MISS   = 2'd3;

  typedef struct packed {
    logic                      cmd;
    logic signed [COORD_W-1:0] begin_x;
    logic signed [COORD_W-1:0] begin_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] ray_x;
    logic signed [COORD_W-1:0] ray_y;
    logic [15:0]               ray_heading;
  } req_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
  } rsp_t;

  // Direction unit result
  typedef struct packed {
    logic                    done;
    logic signed [DIR_W-1:0] dx;
    logic signed [DIR_W-1:0] dy;
  } dir_t;

  // Divider request and result
  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] numer;
    logic [MAG_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  // Arctangent of 2^-i as a 32-bit binary angle
  function automatic logic signed [ANG_W-1:0] atan_bam(input logic [4:0] idx);
    case (idx)
      5'd0:    return ANG_W'(536870912);
      5'd1:    return ANG_W'(316933406);
      5'd2:    return ANG_W'(167458907);
      5'd3:    return ANG_W'(85004756);
      5'd4:    return ANG_W'(42667331);
      5'd5:    return ANG_W'(21354465);
      5'd6:    return ANG_W'(10679838);
      5'd7:    return ANG_W'(5340245);
      5'd8:    return ANG_W'(2670163);
      5'd9:    return ANG_W'(1335087);
      5'd10:   return ANG_W'(667544);
      5'd11:   return ANG_W'(333772);
      5'd12:   return ANG_W'(166886);
      5'd13:   return ANG_W'(83443);
      5'd14:   return ANG_W'(41722);
      5'd15:   return ANG_W'(20861);
      5'd16:   return ANG_W'(10430);
      5'd17:   return ANG_W'(5215);
      5'd18:   return ANG_W'(2608);
      5'd19:   return ANG_W'(1304);
      5'd20:   return ANG_W'(652);
      5'd21:   return ANG_W'(326);
      5'd22:   return ANG_W'(163);
      5'd23:   return ANG_W'(81);
      default: return ANG_W'(0);
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nwrc_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module nwrc_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/nwrc_cordic.sv =====
// Iterative rotation-mode CORDIC: heading to (cos, sin), one step per cycle.
`timescale 1ns / 1ps
`default_nettype none

module nwrc_cordic (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] heading,
  output nwrc_pkg::dir_t   dir
);

  logic                                  busy;
  logic                                  done;
  logic                                  flip;
  logic [nwrc_pkg::ITER_W-1:0]           iter;
  logic signed [nwrc_pkg::DIR_W-1:0]     x;
  logic signed [nwrc_pkg::DIR_W-1:0]     y;
  logic signed [nwrc_pkg::ANG_W-1:0]     z;

  logic [31:0]                           ang;
  logic                                  flip_in;
  logic [31:0]                           ang_f;
  logic signed [nwrc_pkg::DIR_W-1:0]     xs;
  logic signed [nwrc_pkg::DIR_W-1:0]     ys;
  logic signed [nwrc_pkg::ANG_W-1:0]     step_ang;

  // Fold second and third quadrants by a half turn
  assign ang     = {heading, 16'h0000};
  assign flip_in = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
  assign ang_f   = flip_in ? (ang ^ 32'h8000_0000) : ang;

  // Arithmetic shifts round toward minus infinity
  assign xs       = x >>> iter;
  assign ys       = y >>> iter;
  assign step_ang = nwrc_pkg::atan_bam(5'(iter));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
        x    <= nwrc_pkg::CORDIC_X0;
        y    <= '0;
        z    <= nwrc_pkg::ANG_W'($signed(ang_f));
        flip <= flip_in;
      end else if (busy) begin
        if (!z[nwrc_pkg::ANG_W-1]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - step_ang;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + step_ang;
        end
        iter <= iter + 1'b1;
        if (iter == nwrc_pkg::ITER_W'(nwrc_pkg::TRIG_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign dir.done = done;
  assign dir.dx   = flip ? -x : x;
  assign dir.dy   = flip ? -y : y;

endmodule

`default_nettype wire

// ===== rtl/core/nwrc_div.sv =====
// Restoring divider, one quotient bit per cycle, result rounded half away.
`timescale 1ns / 1ps
`default_nettype none

module nwrc_div (
  input  wire logic           clk,
  input  wire logic           rst,
  input  nwrc_pkg::div_req_t  req,
  output nwrc_pkg::div_rsp_t  rsp
);

  logic                          busy;
  logic                          done;
  logic [nwrc_pkg::DCNT_W-1:0]   cnt;
  logic [nwrc_pkg::MAG_W-1:0]    den_q;
  logic [nwrc_pkg::MAG_W-1:0]    rem;
  logic [nwrc_pkg::QUO_W-1:0]    low;

  logic [nwrc_pkg::MAG_W:0]      trial;
  logic [nwrc_pkg::MAG_W:0]      diff;
  logic                          ge;
  logic                          rnd;

  // Low bits of the dividend shift out while quotient bits shift in
  assign trial = {rem, low[nwrc_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};
  assign rnd   = rem >= (den_q - rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= nwrc_pkg::DCNT_W'(nwrc_pkg::QUO_W);
        den_q <= req.den;
        rem   <= req.numer[nwrc_pkg::PROD_W-1:nwrc_pkg::QUO_W];
        low   <= req.numer[nwrc_pkg::QUO_W-1:0];
      end else if (busy) begin
        rem <= ge ? diff[nwrc_pkg::MAG_W-1:0] : trial[nwrc_pkg::MAG_W-1:0];
        low <= {low[nwrc_pkg::QUO_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == nwrc_pkg::DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = low + nwrc_pkg::QUO_W'(rnd);

endmodule

`default_nettype wire

// ===== rtl/core/nearest_wall_ray_cast_core.sv =====
// Top level: wall table memories, per-wall intersection sequencer, result register.
// An add goes from S_IDLE to S_OUT for its result. A query first computes the direction,
// then for each stored wall runs the range test, the forward test and the distance
// compare, leaving a wall early when it is out of range or behind, and ends in S_FIN.
// One item is in work at a time.
// Reset: wall count cleared; table contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module nearest_wall_ray_cast_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  nwrc_pkg::req_t      req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output nwrc_pkg::rsp_t      rsp
);

  typedef enum logic [4:0] {
    S_IDLE, S_TRIG, S_RD, S_LOAD, S_DEN0, S_DEN1, S_NUM0, S_NUM1, S_CHK,
    S_PX0, S_PX1, S_PY0, S_PY1, S_DIVGO, S_DIVW, S_HIT, S_DOT0, S_DOT1,
    S_SQX0, S_SQX1, S_SQY0, S_SQY1, S_BEST, S_FIN, S_OUT
  } state_t;

  state_t                                   state;
  logic [nwrc_pkg::CNT_W-1:0]               wall_count;
  logic [nwrc_pkg::CNT_W-1:0]               k;

  logic signed [nwrc_pkg::COORD_W-1:0]      px, py;
  logic signed [nwrc_pkg::DIR_W-1:0]        dx, dy;
  logic signed [nwrc_pkg::COORD_W-1:0]      ax, ay;
  logic signed [nwrc_pkg::DIFF_W-1:0]       wx, wy, relx, rely;
  logic signed [nwrc_pkg::DEN_W-1:0]        den, num;
  logic [nwrc_pkg::PROD_W-1:0]              tx, ty;
  logic signed [nwrc_pkg::COORD_W-1:0]      hx, hy;
  logic signed [nwrc_pkg::EX_W-1:0]         ex, ey;
  logic signed [nwrc_pkg::DOT_W-1:0]        dot;
  logic [nwrc_pkg::SQ_W-1:0]                sqx, sqy;
  logic                                     found;
  logic [nwrc_pkg::DIST_W-1:0]              best_d;
  logic signed [nwrc_pkg::COORD_W-1:0]      best_x, best_y;
  logic [1:0]                               res_status;
  logic signed [nwrc_pkg::COORD_W-1:0]      res_x, res_y;

  logic                                     req_acc;
  logic                                     add_ok;
  logic                                     last_wall;
  logic [nwrc_pkg::WALL_IDX_W-1:0]          ram_addr;
  logic [nwrc_pkg::PT_W-1:0]                start_rd, finish_rd;
  logic                                     cordic_go;
  nwrc_pkg::dir_t                           dir;
  nwrc_pkg::div_req_t                       divx_req, divy_req;
  nwrc_pkg::div_rsp_t                       divx_rsp, divy_rsp;

  logic [nwrc_pkg::DIFF_W-1:0]              magx, magy;
  logic signed [nwrc_pkg::MA_W-1:0]         mul_a;
  logic signed [nwrc_pkg::MB_W-1:0]         mul_b;
  logic signed [nwrc_pkg::MP_W-1:0]         mul_p;
  logic signed [nwrc_pkg::DEN_W-1:0]        den_abs, num_adj;
  logic signed [nwrc_pkg::HIT_W-1:0]        offx, offy;
  logic signed [nwrc_pkg::DOT_W-1:0]        dot_sum;
  logic [nwrc_pkg::DIST_W-1:0]              range_sq;

  // Handshake and table write
  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign add_ok    = req_acc && (req.cmd == nwrc_pkg::CMD_ADD)
                     && (wall_count < nwrc_pkg::CNT_W'(nwrc_pkg::MAX_WALLS));
  assign cordic_go = req_acc && (req.cmd == nwrc_pkg::CMD_RAY);
  assign ram_addr  = (state == S_IDLE) ? wall_count[nwrc_pkg::WALL_IDX_W-1:0]
                                       : k[nwrc_pkg::WALL_IDX_W-1:0];
  assign last_wall = ((k + nwrc_pkg::CNT_W'(1)) == wall_count);

  nwrc_ram #(.DEPTH(nwrc_pkg::MAX_WALLS), .WIDTH(nwrc_pkg::PT_W)) u_start_ram (
    .clk   (clk),
    .we    (add_ok),
    .addr  (ram_addr),
    .wdata ({req.begin_x, req.begin_y}),
    .rdata (start_rd)
  );

  nwrc_ram #(.DEPTH(nwrc_pkg::MAX_WALLS), .WIDTH(nwrc_pkg::PT_W)) u_finish_ram (
    .clk   (clk),
    .we    (add_ok),
    .addr  (ram_addr),
    .wdata ({req.end_x, req.end_y}),
    .rdata (finish_rd)
  );

  nwrc_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_go),
    .heading (req.ray_heading),
    .dir     (dir)
  );

  // Both coordinates divide in parallel
  assign divx_req.start = (state == S_DIVGO);
  assign divx_req.numer = tx;
  assign divx_req.den   = den[nwrc_pkg::MAG_W-1:0];
  assign divy_req.start = (state == S_DIVGO);
  assign divy_req.numer = ty;
  assign divy_req.den   = den[nwrc_pkg::MAG_W-1:0];

  nwrc_div u_div_x (.clk(clk), .rst(rst), .req(divx_req), .rsp(divx_rsp));
  nwrc_div u_div_y (.clk(clk), .rst(rst), .req(divy_req), .rsp(divy_rsp));

  // Wall vector magnitudes
  assign magx = wx[nwrc_pkg::DIFF_W-1] ? nwrc_pkg::DIFF_W'(-wx) : nwrc_pkg::DIFF_W'(wx);
  assign magy = wy[nwrc_pkg::DIFF_W-1] ? nwrc_pkg::DIFF_W'(-wy) : nwrc_pkg::DIFF_W'(wy);

  // Shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_DEN0: begin mul_a = nwrc_pkg::MA_W'(wy);   mul_b = nwrc_pkg::MB_W'(dx); end
      S_DEN1: begin mul_a = nwrc_pkg::MA_W'(wx);   mul_b = nwrc_pkg::MB_W'(dy); end
      S_NUM0: begin mul_a = nwrc_pkg::MA_W'(relx); mul_b = nwrc_pkg::MB_W'(dy); end
      S_NUM1: begin mul_a = nwrc_pkg::MA_W'(rely); mul_b = nwrc_pkg::MB_W'(dx); end
      S_PX0: begin
        mul_a = nwrc_pkg::MA_W'(num);
        mul_b = nwrc_pkg::MB_W'(magx[nwrc_pkg::CHUNK_W-1:0]);
      end
      S_PX1: begin
        mul_a = nwrc_pkg::MA_W'(num);
        mul_b = nwrc_pkg::MB_W'(magx[nwrc_pkg::DIFF_W-1:nwrc_pkg::CHUNK_W]);
      end
      S_PY0: begin
        mul_a = nwrc_pkg::MA_W'(num);
        mul_b = nwrc_pkg::MB_W'(magy[nwrc_pkg::CHUNK_W-1:0]);
      end
      S_PY1: begin
        mul_a = nwrc_pkg::MA_W'(num);
        mul_b = nwrc_pkg::MB_W'(magy[nwrc_pkg::DIFF_W-1:nwrc_pkg::CHUNK_W]);
      end
      S_DOT0: begin mul_a = nwrc_pkg::MA_W'(ex); mul_b = nwrc_pkg::MB_W'(dx); end
      S_DOT1: begin mul_a = nwrc_pkg::MA_W'(ey); mul_b = nwrc_pkg::MB_W'(dy); end
      S_SQX0: begin
        mul_a = nwrc_pkg::MA_W'(ex);
        mul_b = nwrc_pkg::MB_W'(ex[nwrc_pkg::CHUNK_W-1:0]);
      end
      S_SQX1: begin
        mul_a = nwrc_pkg::MA_W'(ex);
        mul_b = nwrc_pkg::MB_W'(ex >>> nwrc_pkg::CHUNK_W);
      end
      S_SQY0: begin
        mul_a = nwrc_pkg::MA_W'(ey);
        mul_b = nwrc_pkg::MB_W'(ey[nwrc_pkg::CHUNK_W-1:0]);
      end
      S_SQY1: begin
        mul_a = nwrc_pkg::MA_W'(ey);
        mul_b = nwrc_pkg::MB_W'(ey >>> nwrc_pkg::CHUNK_W);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Sign normalization, hit offsets, forward test, distance
  assign den_abs = den[nwrc_pkg::DEN_W-1] ? -den : den;
  assign num_adj = den[nwrc_pkg::DEN_W-1] ? -num : num;
  assign offx = wx[nwrc_pkg::DIFF_W-1] ? -nwrc_pkg::HIT_W'(divx_rsp.quo)
                                       : nwrc_pkg::HIT_W'(divx_rsp.quo);
  assign offy = wy[nwrc_pkg::DIFF_W-1] ? -nwrc_pkg::HIT_W'(divy_rsp.quo)
                                       : nwrc_pkg::HIT_W'(divy_rsp.quo);
  assign dot_sum  = dot + nwrc_pkg::DOT_W'(mul_p);
  assign range_sq = {1'b0, sqx} + {1'b0, sqy};

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      wall_count <= '0;
      rsp_valid  <= 1'b0;
      found      <= 1'b0;
    end else begin
      // A new result in S_OUT takes precedence over retiring the old one
      if (rsp_valid && !rsp_stall && (state != S_OUT)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_acc) begin
            if (req.cmd == nwrc_pkg::CMD_ADD) begin
              res_status <= add_ok ? nwrc_pkg::ST_STORED : nwrc_pkg::ST_FULL;
              res_x      <= '0;
              res_y      <= '0;
              if (add_ok) begin
                wall_count <= wall_count + 1'b1;
              end
              state <= S_OUT;
            end else begin
              px    <= req.ray_x;
              py    <= req.ray_y;
              found <= 1'b0;
              k     <= '0;
              state <= S_TRIG;
            end
          end
        end
        S_TRIG: begin
          if (dir.done) begin
            dx    <= dir.dx;
            dy    <= dir.dy;
            state <= (wall_count == '0) ? S_FIN : S_RD;
          end
        end
        S_RD: state <= S_LOAD;
        S_LOAD: begin
          ax   <= start_rd[nwrc_pkg::PT_W-1:nwrc_pkg::COORD_W];
          ay   <= start_rd[nwrc_pkg::COORD_W-1:0];
          wx   <= nwrc_pkg::DIFF_W'($signed(finish_rd[nwrc_pkg::PT_W-1:nwrc_pkg::COORD_W]))
                - nwrc_pkg::DIFF_W'($signed(start_rd[nwrc_pkg::PT_W-1:nwrc_pkg::COORD_W]));
          wy   <= nwrc_pkg::DIFF_W'($signed(finish_rd[nwrc_pkg::COORD_W-1:0]))
                - nwrc_pkg::DIFF_W'($signed(start_rd[nwrc_pkg::COORD_W-1:0]));
          relx <= nwrc_pkg::DIFF_W'($signed(start_rd[nwrc_pkg::PT_W-1:nwrc_pkg::COORD_W]))
                - nwrc_pkg::DIFF_W'(px);
          rely <= nwrc_pkg::DIFF_W'($signed(start_rd[nwrc_pkg::COORD_W-1:0]))
                - nwrc_pkg::DIFF_W'(py);
          state <= S_DEN0;
        end
        S_DEN0: begin
          den   <= nwrc_pkg::DEN_W'(mul_p);
          state <= S_DEN1;
        end
        S_DEN1: begin
          den   <= den - nwrc_pkg::DEN_W'(mul_p);
          state <= S_NUM0;
        end
        S_NUM0: begin
          num   <= nwrc_pkg::DEN_W'(mul_p);
          state <= S_NUM1;
        end
        S_NUM1: begin
          num   <= num - nwrc_pkg::DEN_W'(mul_p);
          state <= S_CHK;
        end
        // Parallel lines and points outside the segment are skipped
        S_CHK: begin
          if ((den == '0) || num_adj[nwrc_pkg::DEN_W-1] || (num_adj > den_abs)) begin
            state <= last_wall ? S_FIN : S_RD;
            if (!last_wall) k <= k + 1'b1;
          end else begin
            den   <= den_abs;
            num   <= num_adj;
            state <= S_PX0;
          end
        end
        S_PX0: begin
          tx    <= nwrc_pkg::PROD_W'(mul_p);
          state <= S_PX1;
        end
        S_PX1: begin
          tx    <= tx + (nwrc_pkg::PROD_W'(mul_p) << nwrc_pkg::CHUNK_W);
          state <= S_PY0;
        end
        S_PY0: begin
          ty    <= nwrc_pkg::PROD_W'(mul_p);
          state <= S_PY1;
        end
        S_PY1: begin
          ty    <= ty + (nwrc_pkg::PROD_W'(mul_p) << nwrc_pkg::CHUNK_W);
          state <= S_DIVGO;
        end
        S_DIVGO: state <= S_DIVW;
        S_DIVW: begin
          if (divx_rsp.done && divy_rsp.done) begin
            state <= S_HIT;
          end
        end
        S_HIT: begin
          hx    <= ax + offx[nwrc_pkg::COORD_W-1:0];
          hy    <= ay + offy[nwrc_pkg::COORD_W-1:0];
          ex    <= nwrc_pkg::EX_W'(relx) + nwrc_pkg::EX_W'(offx);
          ey    <= nwrc_pkg::EX_W'(rely) + nwrc_pkg::EX_W'(offy);
          state <= S_DOT0;
        end
        S_DOT0: begin
          dot   <= nwrc_pkg::DOT_W'(mul_p);
          state <= S_DOT1;
        end
        // Points behind the robot are skipped
        S_DOT1: begin
          if (dot_sum[nwrc_pkg::DOT_W-1]) begin
            state <= last_wall ? S_FIN : S_RD;
            if (!last_wall) k <= k + 1'b1;
          end else begin
            state <= S_SQX0;
          end
        end
        S_SQX0: begin
          sqx   <= nwrc_pkg::SQ_W'(mul_p);
          state <= S_SQX1;
        end
        S_SQX1: begin
          sqx   <= sqx + (nwrc_pkg::SQ_W'(mul_p) << nwrc_pkg::CHUNK_W);
          state <= S_SQY0;
        end
        S_SQY0: begin
          sqy   <= nwrc_pkg::SQ_W'(mul_p);
          state <= S_SQY1;
        end
        S_SQY1: begin
          sqy   <= sqy + (nwrc_pkg::SQ_W'(mul_p) << nwrc_pkg::CHUNK_W);
          state <= S_BEST;
        end
        // Strictly nearer only, so the earliest wall wins a tie
        S_BEST: begin
          if (!found || (range_sq < best_d)) begin
            found  <= 1'b1;
            best_d <= range_sq;
            best_x <= hx;
            best_y <= hy;
          end
          state <= last_wall ? S_FIN : S_RD;
          if (!last_wall) k <= k + 1'b1;
        end
        S_FIN: begin
          res_status <= found ? nwrc_pkg::ST_HIT : nwrc_pkg::ST_MISS;
          res_x      <= found ? best_x : '0;
          res_y      <= found ? best_y : '0;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid  <= 1'b1;
            rsp.status <= res_status;
            rsp.hit_x  <= res_x;
            rsp.hit_y  <= res_y;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    wall_count <= nwrc_pkg::CNT_W'(nwrc_pkg::MAX_WALLS))
    else $error("wall count beyond table size");

  a_add_counts: assert property (@(posedge clk) disable iff (rst)
    add_ok |=> (wall_count == $past(wall_count) + 1'b1))
    else $error("stored wall not counted");

  a_zero_unless_hit: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status != nwrc_pkg::ST_HIT))
      |-> ((rsp.hit_x == '0) && (rsp.hit_y == '0)))
    else $error("hit point not zero without a hit");

  a_full_no_write: assert property (@(posedge clk) disable iff (rst)
    (req_acc && (req.cmd == nwrc_pkg::CMD_ADD)
      && (wall_count == nwrc_pkg::CNT_W'(nwrc_pkg::MAX_WALLS))) |-> !add_ok)
    else $error("write into a full table");
`endif

endmodule

`default_nettype wire

// ===== dv/nearest_wall_ray_cast_core_test.sv =====
// Self-checking testbench for the nearest wall ray cast core.
`timescale 1ns / 1ps

module nearest_wall_ray_cast_core_test;
  import nwrc_pkg::*;

  localparam int  LIMIT_CYCLES = 30_000_000;
  localparam int  LOCAL_SPAN   = 16 * 65536;  // +-16 m in Q16.16

  typedef struct {
    req_t item;
    bit   typed;
    rsp_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Own copy of the wall table
  longint wall_ax[MAX_WALLS];
  longint wall_ay[MAX_WALLS];
  longint wall_bx[MAX_WALLS];
  longint wall_by[MAX_WALLS];
  int     walls_held = 0;

  rsp_t      pending_rsp[$];
  stim_row_t directed[$];
  int        errors = 0;
  longint    cycles = 0;
  bit        quiet = 1'b0;

  // Arctangent of 2^-i as a 32-bit binary angle
  longint arc_step[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  nearest_wall_ray_cast_core u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // CORDIC rotation: heading to (cos, sin) with TRIG_BITS fraction bits
  function automatic void heading_to_dir(input logic [15:0] heading,
                                         output longint cx, output longint sy);
    logic [31:0] ang;
    bit          flip;
    longint      x, y, z, nx, ny;
    ang  = {heading, 16'h0};
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang = ang + 32'h8000_0000;
    z = longint'($signed(ang));
    x = longint'(CORDIC_X0);
    y = 0;
    for (int i = 0; i < TRIG_BITS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - arc_step[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + arc_step[i];
      end
      x = nx;
      y = ny;
    end
    cx = flip ? -x : x;
    sy = flip ? -y : y;
  endfunction

  // round(num * w / den), ties away from zero; 0 <= num <= den
  function automatic longint scaled_offset(longint num, longint w, longint den);
    logic [127:0] prod, quo, rem, d;
    d    = 128'(den);
    prod = 128'(num) * 128'(w < 0 ? -w : w);
    quo  = prod / d;
    rem  = prod % d;
    if (rem >= d - rem) quo = quo + 1;
    return (w < 0) ? -longint'(quo) : longint'(quo);
  endfunction

  // Predict the result of one item and update the wall table
  function automatic rsp_t cast_ray(req_t it);
    rsp_t        r;
    longint      px, py, dx, dy, ax, ay, wx, wy, den, num, hx, hy, ex, ey;
    longint      bx, by;
    bit [63:0]   ux, uy, sx, sy, lo;
    bit [64:0]   range_sq, best;
    bit          found;
    r = '0;
    if (it.cmd == CMD_ADD) begin
      if (walls_held >= MAX_WALLS) begin
        r.status = ST_FULL;
      end else begin
        wall_ax[walls_held] = it.begin_x;
        wall_ay[walls_held] = it.begin_y;
        wall_bx[walls_held] = it.end_x;
        wall_by[walls_held] = it.end_y;
        walls_held++;
        r.status = ST_STORED;
      end
      return r;
    end
    px = it.ray_x;
    py = it.ray_y;
    heading_to_dir(it.ray_heading, dx, dy);
    found = 1'b0;
    best  = '0;
    bx    = 0;
    by    = 0;
    for (int k = 0; k < walls_held; k++) begin
      ax  = wall_ax[k];
      ay  = wall_ay[k];
      wx  = wall_bx[k] - ax;
      wy  = wall_by[k] - ay;
      den = dx * wy - dy * wx;
      num = (ax - px) * dy - (ay - py) * dx;
      // parallel lines or a point wall
      if (den == 0) continue;
      if (den < 0) begin
        den = -den;
        num = -num;
      end
      // off the segment
      if (num < 0 || num > den) continue;
      hx = ax + scaled_offset(num, wx, den);
      hy = ay + scaled_offset(num, wy, den);
      ex = hx - px;
      ey = hy - py;
      // behind the robot
      if (ex * dx + ey * dy < 0) continue;
      ux       = (ex < 0) ? -ex : ex;
      uy       = (ey < 0) ? -ey : ey;
      sx       = ux * ux;
      sy       = uy * uy;
      lo       = sx + sy;
      range_sq = {(lo < sx), lo};
      // strict compare keeps the earliest wall on a tie
      if (!found || range_sq < best) begin
        found = 1'b1;
        best  = range_sq;
        bx    = hx;
        by    = hy;
      end
    end
    if (found) begin
      r.status = ST_HIT;
      r.hit_x  = bx[31:0];
      r.hit_y  = by[31:0];
    end else begin
      r.status = ST_MISS;
    end
    return r;
  endfunction

  // Drive one item and wait for it to be taken
  task automatic send_item(req_t it, bit typed, rsp_t want);
    rsp_t pred;
    bit   taken;
    pred = cast_ray(it);
    pending_rsp.insert(pending_rsp.size(), typed ? want : pred);
    while (!quiet && $urandom_range(99) < 15) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= it;
    req_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = !req_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  // Result side: random stall, check against the oldest expectation
  initial begin
    rsp_t want;
    forever begin
      @(negedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          $display("%0t unexpected item: status %0d", $time, rsp.status);
          errors++;
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.status !== want.status) begin
            $display("%0t status: expected %0d actual %0d", $time, want.status,
                     rsp.status);
            errors++;
          end
          if (rsp.hit_x !== want.hit_x) begin
            $display("%0t hit_x: expected %h actual %h", $time, want.hit_x, rsp.hit_x);
            errors++;
          end
          if (rsp.hit_y !== want.hit_y) begin
            $display("%0t hit_y: expected %h actual %h", $time, want.hit_y, rsp.hit_y);
            errors++;
          end
        end
      end
      @(posedge clk);
      rsp_stall <= !quiet && ($urandom_range(99) < 15);
    end
  end

  function automatic int qm(int m);
    return m * 65536;
  endfunction

  function automatic logic signed [31:0] local_coord();
    return $signed($urandom_range(2 * LOCAL_SPAN)) - LOCAL_SPAN;
  endfunction

  function automatic stim_row_t add_row(int bx, int by, int ex, int ey, bit typed);
    stim_row_t s;
    s.item         = '0;
    s.item.cmd     = CMD_ADD;
    s.item.begin_x = bx;
    s.item.begin_y = by;
    s.item.end_x   = ex;
    s.item.end_y   = ey;
    s.typed        = typed;
    s.want         = '{status: ST_STORED, hit_x: '0, hit_y: '0};
    return s;
  endfunction

  function automatic stim_row_t ray_row(int x, int y, logic [15:0] hd);
    stim_row_t s;
    s.item             = '0;
    s.item.cmd         = CMD_RAY;
    s.item.ray_x       = x;
    s.item.ray_y       = y;
    s.item.ray_heading = hd;
    s.typed            = 1'b0;
    s.want             = '0;
    return s;
  endfunction

  // Stimulus
  initial begin
    stim_row_t s;
    req_t      it;
    int        n_rand;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    s = ray_row(0, 0, 16'd0);              // empty table
    s.typed = 1'b1;
    s.want  = '{status: ST_MISS, hit_x: '0, hit_y: '0};
    directed.insert(directed.size(), s);
    directed.insert(directed.size(), add_row(qm(10), qm(-5), qm(10), qm(5), 1'b1));
    directed.insert(directed.size(), add_row(qm(3), qm(3), qm(3), qm(3), 1'b1)); // point
    directed.insert(directed.size(), add_row(0, qm(2), qm(20), qm(2), 1'b1));  // along +x
    directed.insert(directed.size(), add_row(qm(10), qm(-5), qm(10), qm(5), 1'b1)); // dup
    directed.insert(directed.size(), add_row(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                                             32'h7fff_ffff, 1'b1));
    directed.insert(directed.size(), add_row(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                                             32'h7fff_ffff, 1'b1));
    s = add_row(qm(-8), qm(-8), qm(-8), qm(8), 1'b1);                  // ray fields ignored
    s.item.ray_x = '1; s.item.ray_y = '1; s.item.ray_heading = '1;
    directed.insert(directed.size(), s);
    directed.insert(directed.size(), ray_row(0, 0, 16'd0));
    directed.insert(directed.size(), ray_row(0, 0, 16'd16384));
    directed.insert(directed.size(), ray_row(0, 0, 16'd32768));
    directed.insert(directed.size(), ray_row(0, 0, 16'd49152));
    directed.insert(directed.size(), ray_row(0, 0, 16'd65535));
    directed.insert(directed.size(), ray_row(0, 0, 16'd8192));
    directed.insert(directed.size(), ray_row(qm(20), 0, 16'd0));       // walls behind
    directed.insert(directed.size(), ray_row(qm(10), 0, 16'd0));       // robot on the wall
    directed.insert(directed.size(), ray_row(32'h8000_0000, 32'h8000_0000, 16'd8192));
    directed.insert(directed.size(), ray_row(32'h7fff_ffff, 32'h7fff_ffff, 16'd40960));
    s = ray_row(qm(1), qm(-1), 16'd24576);               // wall fields ignored
    s.item.begin_x = '1; s.item.begin_y = '1; s.item.end_x = '1; s.item.end_y = '1;
    directed.insert(directed.size(), s);
    foreach (directed[i]) send_item(directed[i].item, directed[i].typed,
                                    directed[i].want);

    // Drain completely before going on
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);

    // Random items: mostly local walls and rays so hits are common
    n_rand = 1830;
    for (int i = 0; i < n_rand; i++) begin
      quiet = (i >= 500 && i < 700);
      it = '0;
      it.begin_x = $urandom; it.begin_y = $urandom;
      it.end_x   = $urandom; it.end_y   = $urandom;
      it.ray_x   = $urandom; it.ray_y   = $urandom;
      it.ray_heading = 16'($urandom);
      if (walls_held < MAX_WALLS) it.cmd = ($urandom_range(1) == 0) ? CMD_ADD : CMD_RAY;
      else                        it.cmd = ($urandom_range(9) < 4) ? CMD_ADD : CMD_RAY;
      if (it.cmd == CMD_ADD && $urandom_range(9) < 8) begin
        it.begin_x = local_coord(); it.begin_y = local_coord();
        it.end_x   = local_coord(); it.end_y   = local_coord();
        // axis-aligned walls now and then
        if ($urandom_range(9) == 0) it.end_x = it.begin_x;
        if ($urandom_range(9) == 0) it.end_y = it.begin_y;
      end
      if (it.cmd == CMD_RAY && $urandom_range(99) < 85) begin
        it.ray_x = local_coord();
        it.ray_y = local_coord();
      end
      send_item(it, 1'b0, '0);
      if (i == 1000) begin
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
      end
    end
    req_valid <= 1'b0;
    quiet = 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
